/* sv/hpwm_pkg.sv */
// shared types, codes and constants for the h-bridge pwm motor controller
`default_nettype none

package hpwm_pkg;

  // physical channels and counter width
  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 10;
  localparam int DRIVE_W     = 11;
  localparam int PINS_W      = 2 * CHANNELS;

  typedef logic [COUNT_WIDTH-1:0]                count_t;
  typedef logic signed [DRIVE_W-1:0]             drive_t;
  typedef logic [CHANNELS-1:0][COUNT_WIDTH-1:0]  cmp_bank_t;
  typedef logic [PINS_W-1:0]                     pins_t;
  typedef logic [1:0]                            chan_t;

  // item commands
  typedef enum logic [1:0] {
    CMD_SET     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FLIP_MASK = 2'd0,
    REG_CHAN_MAP  = 2'd1,
    REG_PERIOD    = 2'd2
  } reg_idx_t;

  // configuration reset values
  localparam logic [3:0] FLIP_MASK_RST = 4'd1;
  localparam logic [7:0] CHAN_MAP_RST  = 8'd30;
  localparam count_t     PERIOD_RST    = count_t'(1023);

  // pin mask with in1 of every channel
  localparam pins_t IN1_MASK = pins_t'(8'h55);

  // operands of the set/read datapath
  typedef struct packed {
    logic [1:0] motor_index;
    drive_t     drive_value;
    logic [3:0] flip_mask;
    logic [7:0] chan_map;
    count_t     period;
    pins_t      pins;
    cmp_bank_t  active;
  } calc_in_t;

  // results of the set/read datapath
  typedef struct packed {
    chan_t  chan;
    pins_t  set_pins;
    count_t set_mag;
    drive_t read_val;
  } calc_out_t;

endpackage

`default_nettype wire

/* sv/hpwm_if.sv */
// valid/ready channel interfaces for command items and result items
`default_nettype none

interface hpwm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [1:0]         motor_index;
  logic signed [10:0] drive_value;

  modport source(output valid, output command, output motor_index, output drive_value,
                 input ready);
  modport sink(input valid, input command, input motor_index, input drive_value,
               output ready);
endinterface

interface hpwm_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         direction_pins;
  logic [3:0]         pwm_lines;
  logic signed [10:0] read_drive;

  modport source(output valid, output direction_pins, output pwm_lines, output read_drive,
                 input ready);
  modport sink(input valid, input direction_pins, input pwm_lines, input read_drive,
               output ready);
endinterface

`default_nettype wire

/* sv/hpwm_drive_calc.sv */
// channel mapping, sign handling, saturation and drive read-back for one item
`default_nettype none

module hpwm_drive_calc import hpwm_pkg::*; (
  input  calc_in_t  calc_in,
  output calc_out_t calc_out
);

  chan_t              chan;
  logic               flip;
  logic signed [11:0] drv_ext;
  logic signed [11:0] drv_signed;
  logic               drv_neg;
  logic               drv_nz;
  logic [11:0]        drv_abs;
  count_t             mag;
  pins_t              pins_nxt;
  count_t             act_cmp;
  logic               read_neg;
  drive_t             read_abs;

  always_comb begin
    // logical motor to physical channel
    chan = calc_in.chan_map[{calc_in.motor_index, 1'b0} +: 2];
    flip = calc_in.flip_mask[calc_in.motor_index];

    // signed drive, widened so that the most negative value negates cleanly
    drv_ext    = {calc_in.drive_value[DRIVE_W-1], calc_in.drive_value};
    drv_signed = flip ? -drv_ext : drv_ext;
    drv_neg    = drv_signed[11];
    drv_nz     = |drv_signed;
    drv_abs    = drv_neg ? 12'(-drv_signed) : 12'(drv_signed);

    // saturate magnitude at the period
    if (drv_abs[10:0] > {1'b0, calc_in.period}) begin
      mag = calc_in.period;
    end else begin
      mag = drv_abs[COUNT_WIDTH-1:0];
    end

    // forward sets in1, reverse sets in2, zero clears both
    pins_nxt                   = calc_in.pins;
    pins_nxt[{chan, 1'b0}]     = drv_nz & ~drv_neg;
    pins_nxt[{chan, 1'b0} + 1] = drv_neg;

    // read-back: active compare, signed by in1 and the flip bit
    act_cmp  = calc_in.active[chan];
    read_neg = ~calc_in.pins[{chan, 1'b0}] ^ flip;
    read_abs = drive_t'({1'b0, act_cmp});

    calc_out.chan     = chan;
    calc_out.set_pins = pins_nxt;
    calc_out.set_mag  = mag;
    calc_out.read_val = read_neg ? -read_abs : read_abs;
  end

endmodule

`default_nettype wire

/* sv/hbridge_pwm_motor_controller.sv */
// top level of the four-channel sign-magnitude h-bridge pwm controller
//
//  port     | dir  | handshake       | payload
//  ---------+------+-----------------+---------------------------------------------
//  in_ch    | in   | valid/ready     | command, motor_index, drive_value
//  out_ch   | out  | valid/ready     | direction_pins, pwm_lines, read_drive
//  cfg_*    | in   | cfg_we          | cfg_index, cfg_wdata (flip mask, map, period)
//
// one item per cycle while no result is held back by a low out_ch.ready; its result is
// registered at the accepting edge and appears in the output register in the next cycle;
// state (counter, compares, pins) is updated at that same edge, so the next item sees it at once
// in_ch.ready drops only while a result is held and out_ch.ready is low
// synchronous active-low reset clears state and loads the register defaults
`default_nettype none

module hbridge_pwm_motor_controller import hpwm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hpwm_in_if.sink    in_ch,
  hpwm_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  // configuration registers
  logic [3:0] flip_mask_r;
  logic [7:0] chan_map_r;
  count_t     period_r;

  // pwm state
  count_t    counter_r, counter_nxt;
  cmp_bank_t buf_r, buf_nxt;
  cmp_bank_t act_r, act_nxt;
  pins_t     pins_r, pins_nxt;

  // result register
  logic        out_valid_r;
  pins_t       out_pins_r, out_pins_nxt;
  logic [3:0]  out_pwm_r, out_pwm_nxt;
  drive_t      out_read_r, out_read_nxt;

  logic      in_ready;
  logic      in_accept;
  cmd_t      cmd;
  calc_in_t  calc_in;
  calc_out_t calc_out;

  assign in_ready     = ~out_valid_r | out_ch.ready;
  assign in_accept    = in_ch.valid & in_ready;
  assign in_ch.ready  = in_ready;
  assign cmd          = cmd_t'(in_ch.command);

  // set/read datapath
  always_comb begin
    calc_in.motor_index = in_ch.motor_index;
    calc_in.drive_value = in_ch.drive_value;
    calc_in.flip_mask   = flip_mask_r;
    calc_in.chan_map    = chan_map_r;
    calc_in.period      = period_r;
    calc_in.pins        = pins_r;
    calc_in.active      = act_r;
  end

  hpwm_drive_calc u_drive_calc (
    .calc_in  (calc_in),
    .calc_out (calc_out)
  );

  // next state per command
  always_comb begin
    counter_nxt  = counter_r;
    buf_nxt      = buf_r;
    act_nxt      = act_r;
    pins_nxt     = pins_r;
    out_read_nxt = '0;
    case (cmd)
      CMD_SET: begin
        pins_nxt               = calc_out.set_pins;
        buf_nxt[calc_out.chan] = calc_out.set_mag;
      end
      CMD_READ: begin
        out_read_nxt = calc_out.read_val;
      end
      CMD_ALL_OFF: begin
        buf_nxt = '0;
      end
      CMD_TICK: begin
        // wrap at or past the period and load the buffered compares
        if (counter_r >= period_r) begin
          counter_nxt = '0;
          act_nxt     = buf_r;
        end else begin
          counter_nxt = counter_r + count_t'(1);
        end
      end
      default: begin
        counter_nxt = counter_r;
      end
    endcase
  end

  // pwm lines after the step
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      out_pwm_nxt[c] = counter_nxt < act_nxt[c];
    end
    out_pins_nxt = pins_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_mask_r <= FLIP_MASK_RST;
      chan_map_r  <= CHAN_MAP_RST;
      period_r    <= PERIOD_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FLIP_MASK: flip_mask_r <= cfg_wdata[3:0];
        REG_CHAN_MAP:  chan_map_r  <= cfg_wdata[7:0];
        REG_PERIOD:    period_r    <= cfg_wdata[COUNT_WIDTH-1:0];
        default:       period_r    <= period_r;
      endcase
    end
  end

  // pwm state update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      buf_r     <= '0;
      act_r     <= '0;
      pins_r    <= '0;
    end else if (in_accept) begin
      counter_r <= counter_nxt;
      buf_r     <= buf_nxt;
      act_r     <= act_nxt;
      pins_r    <= pins_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_pins_r <= out_pins_nxt;
      out_pwm_r  <= out_pwm_nxt;
      out_read_r <= out_read_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.direction_pins = out_pins_r;
  assign out_ch.pwm_lines      = out_pwm_r;
  assign out_ch.read_drive     = out_read_r;

endmodule

`default_nettype wire

/* sv/hpwm_checker.sv */
// port-level checks for the h-bridge pwm controller, bound to the top level
`default_nettype none

module hpwm_checker import hpwm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic [7:0]         out_direction_pins,
  input logic [3:0]         out_pwm_lines,
  input logic signed [10:0] out_read_drive
);

  // no result left over from before reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every accepted item yields a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  // only a read returns a drive
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_READ |=> out_read_drive == '0)
    else $error("nonzero read_drive for a non-read item");

  // never both bridge inputs of one channel high
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_direction_pins & (out_direction_pins >> 1) & IN1_MASK) == '0)
    else $error("in1 and in2 high together");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_direction_pins)
      && $stable(out_pwm_lines) && $stable(out_read_drive))
    else $error("stalled result changed");

endmodule

bind hbridge_pwm_motor_controller hpwm_checker u_hpwm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_command         (in_ch.command),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_direction_pins (out_ch.direction_pins),
  .out_pwm_lines      (out_ch.pwm_lines),
  .out_read_drive     (out_ch.read_drive)
);

`default_nettype wire

/* verif/tb_hbridge_pwm_motor_controller.sv */
// testbench for the h-bridge pwm motor controller: directed table, then random items per setting
`timescale 1ns / 1ps

module tb_hbridge_pwm_motor_controller;
  import hpwm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int N_DIRECTED  = 18;
  localparam int PHASE_ITEMS = 135;

  // one result item of the block
  typedef struct packed {
    pins_t      pins;
    logic [3:0] lines;
    drive_t     rd;
  } motor_result_t;

  // one row of the directed table; exp is used only where typed is set
  typedef struct packed {
    cmd_t          cmd;
    logic [1:0]    motor;
    drive_t        drv;
    logic          typed;
    motor_result_t exp;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_wdata;

  hpwm_in_if  in_ch ();
  hpwm_out_if out_ch ();

  hbridge_pwm_motor_controller u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predicted copy of the configuration and the pwm state
  logic [3:0] m_flip;
  logic [7:0] m_chan_map;
  count_t     m_period;
  count_t     m_counter;
  count_t     m_buf [CHANNELS];
  count_t     m_act [CHANNELS];
  pins_t      m_pins;

  motor_result_t expected_results [$];
  logic          row_typed;
  motor_result_t row_exp;
  bit            no_idle;

  int n_errors;
  int n_checked;
  int n_reloads;
  int n_settings;
  int n_cmd [4];
  int stall_cycles;

  // directed items under the reset settings: motors 0..3 on channels 2, 3, 1, 0, motor 0 flipped
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_READ,    2'd0, drive_t'(0),     1'b1, '{8'h00, 4'h0, drive_t'(0)}},
    '{CMD_SET,     2'd1, drive_t'(1023),  1'b1, '{8'h40, 4'h0, drive_t'(0)}},
    '{CMD_SET,     2'd0, drive_t'(1023),  1'b1, '{8'h60, 4'h0, drive_t'(0)}},
    '{CMD_SET,     2'd2, drive_t'(-1024), 1'b1, '{8'h68, 4'h0, drive_t'(0)}},
    '{CMD_SET,     2'd3, drive_t'(0),     1'b1, '{8'h68, 4'h0, drive_t'(0)}},
    '{CMD_READ,    2'd3, drive_t'(0),     1'b1, '{8'h68, 4'h0, drive_t'(0)}},
    '{CMD_SET,     2'd3, drive_t'(-1),    1'b0, '0},
    '{CMD_SET,     2'd0, drive_t'(0),     1'b0, '0},
    '{CMD_SET,     2'd2, drive_t'(1),     1'b0, '0},
    '{CMD_TICK,    2'd0, drive_t'(0),     1'b0, '0},
    '{CMD_TICK,    2'd3, drive_t'(-1),    1'b0, '0},
    '{CMD_ALL_OFF, 2'd1, drive_t'(1023),  1'b0, '0},
    '{CMD_READ,    2'd1, drive_t'(0),     1'b0, '0},
    '{CMD_READ,    2'd2, drive_t'(0),     1'b0, '0},
    '{CMD_SET,     2'd1, drive_t'(-1023), 1'b0, '0},
    '{CMD_SET,     2'd0, drive_t'(-1024), 1'b0, '0},
    '{CMD_TICK,    2'd2, drive_t'(512),   1'b0, '0},
    '{CMD_READ,    2'd0, drive_t'(0),     1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset values of the predicted state
  function automatic void reset_state();
    int c;
    m_flip     = FLIP_MASK_RST;
    m_chan_map = CHAN_MAP_RST;
    m_period   = PERIOD_RST;
    m_counter  = '0;
    m_pins     = '0;
    for (c = 0; c < CHANNELS; c++) begin
      m_buf[c] = '0;
      m_act[c] = '0;
    end
  endfunction

  // advance the predicted state by one item and return the result it causes
  function automatic motor_result_t predict_motor(cmd_t cmd, logic [1:0] motor, drive_t drv);
    int unsigned   ch;
    int unsigned   mag;
    int            sdrv;
    int            rd;
    int            c;
    pins_t         in1;
    pins_t         in2;
    motor_result_t res;
    ch   = m_chan_map[2*motor +: 2];
    sdrv = drv;
    rd   = 0;
    in1  = pins_t'(1) << (2 * ch);
    in2  = in1 << 1;
    case (cmd)
      CMD_SET: begin
        if (m_flip[motor]) sdrv = -sdrv;
        if (sdrv == 0) begin
          m_pins = m_pins & ~(in1 | in2);
          mag    = 0;
        end else if (sdrv > 0) begin
          m_pins = (m_pins & ~in2) | in1;
          mag    = sdrv;
        end else begin
          m_pins = (m_pins & ~in1) | in2;
          mag    = -sdrv;
        end
        // magnitude saturates at the period
        if (mag > m_period) mag = m_period;
        m_buf[ch] = count_t'(mag);
      end
      CMD_READ: begin
        rd = m_act[ch];
        if (!m_pins[2*ch]) rd = -rd;
        if (m_flip[motor]) rd = -rd;
      end
      CMD_ALL_OFF: begin
        for (c = 0; c < CHANNELS; c++) m_buf[c] = '0;
      end
      default: begin
        // wrap at or above the period reloads the active compares
        if (m_counter >= m_period) begin
          m_counter = '0;
          for (c = 0; c < CHANNELS; c++) m_act[c] = m_buf[c];
          n_reloads++;
        end else begin
          m_counter = m_counter + 1'b1;
        end
      end
    endcase
    res.pins = m_pins;
    for (c = 0; c < CHANNELS; c++) res.lines[c] = (m_counter < m_act[c]);
    res.rd = drive_t'(rd);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch on %s in result %0d: got %h, expected %h",
             $time, field, n_checked, got, want);
    n_errors++;
  endtask

  // result checking and prediction at each accepting edge
  always @(posedge clk) begin
    motor_result_t want;
    motor_result_t predicted;
    if (rst_n) begin
      // results first: an item accepted at this edge has no result yet
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 16'(out_ch.direction_pins), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.direction_pins !== want.pins)
            report_mismatch("direction_pins", 16'(out_ch.direction_pins), 16'(want.pins));
          if (out_ch.pwm_lines !== want.lines)
            report_mismatch("pwm_lines", 16'(out_ch.pwm_lines), 16'(want.lines));
          if (out_ch.read_drive !== want.rd)
            report_mismatch("read_drive", 16'(out_ch.read_drive), 16'(want.rd));
        end
        n_checked++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted = predict_motor(cmd_t'(in_ch.command), in_ch.motor_index,
                                  in_ch.drive_value);
        expected_results.push_back(row_typed ? row_exp : predicted);
        n_cmd[in_ch.command]++;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] watchdog: nothing moved for %0d cycles, %0d results pending",
               $time, stall_cycles, expected_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result-side back pressure
  always @(negedge clk) begin
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
  end

  // present one item, with random idle cycles ahead of it, and wait for its accept
  task automatic send_item(input cmd_t cmd, input logic [1:0] motor, input drive_t drv,
                           input logic typed, input motor_result_t exp);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.motor_index <= motor;
    in_ch.drive_value <= drv;
    row_typed         <= typed;
    row_exp           <= exp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // drive values weighted toward the extremes and the current period
  function automatic drive_t pick_drive();
    int r;
    int m;
    r = $urandom_range(99);
    if (r < 12) begin
      case ($urandom_range(3))
        0:       return drive_t'(1023);
        1:       return drive_t'(-1023);
        2:       return drive_t'(-1024);
        default: return drive_t'(0);
      endcase
    end else if (r < 45) begin
      m = int'(m_period) + $urandom_range(4) - 2;
      if (m < 0) m = 0;
      if (m > 1023) m = 1023;
      return $urandom_range(1) ? drive_t'(m) : drive_t'(-m);
    end
    return drive_t'($urandom_range(2047));
  endfunction

  task automatic send_random();
    int   r;
    cmd_t cmd;
    r = $urandom_range(99);
    if (r < 35)      cmd = CMD_SET;
    else if (r < 60) cmd = CMD_READ;
    else if (r < 65) cmd = CMD_ALL_OFF;
    else             cmd = CMD_TICK;
    send_item(cmd, 2'($urandom_range(3)), pick_drive(), 1'b0, '0);
  endtask

  // wait until every expected result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // write all three registers while the block is idle
  task automatic apply_settings(input logic [3:0] flip, input logic [7:0] map,
                                input count_t period);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLIP_MASK;
    cfg_wdata <= 10'(flip);
    @(negedge clk);
    cfg_index <= REG_CHAN_MAP;
    cfg_wdata <= 10'(map);
    @(negedge clk);
    cfg_index <= REG_PERIOD;
    cfg_wdata <= period;
    @(negedge clk);
    cfg_we     <= 1'b0;
    m_flip     = flip;
    m_chan_map = map;
    m_period   = period;
    n_settings++;
  endtask

  task automatic run_phase(input logic [3:0] flip, input logic [7:0] map,
                           input count_t period, input bit steady);
    int i;
    drain();
    apply_settings(flip, map, period);
    no_idle = steady;
    for (i = 0; i < PHASE_ITEMS; i++) send_random();
  endtask

  // stimulus
  initial begin
    int i;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_FLIP_MASK;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_SET;
    in_ch.motor_index = '0;
    in_ch.drive_value = '0;
    out_ch.ready      = 1'b0;
    row_typed         = 1'b0;
    row_exp           = '0;
    no_idle           = 1'b0;
    n_settings        = 1;
    stall_cycles      = 0;
    reset_state();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, then random items under the reset settings
    for (i = 0; i < N_DIRECTED; i++)
      send_item(directed_rows[i].cmd, directed_rows[i].motor, directed_rows[i].drv,
                directed_rows[i].typed, directed_rows[i].exp);
    for (i = 0; i < 100; i++) send_random();

    // settings sweep: period 1, shared channel, longest and zero period, two random, period 12
    run_phase(4'hF, 8'hE4, count_t'(1), 1'b0);
    run_phase(4'h0, 8'h00, count_t'(5), 1'b0);
    run_phase(4'hA, 8'hFF, count_t'(1023), 1'b1);
    run_phase(4'h5, 8'h1B, count_t'(0), 1'b0);
    run_phase(4'($urandom_range(15)), 8'($urandom_range(255)),
              count_t'($urandom_range(2, 40)), 1'b0);
    run_phase(4'($urandom_range(15)), 8'($urandom_range(255)),
              count_t'($urandom_range(41, 300)), 1'b0);
    run_phase(4'h3, 8'h39, count_t'(12), 1'b0);
    drain();

    $display("run covered %0d items (set %0d, read %0d, all-off %0d, tick %0d) over %0d settings",
             n_cmd[CMD_SET] + n_cmd[CMD_READ] + n_cmd[CMD_ALL_OFF] + n_cmd[CMD_TICK],
             n_cmd[CMD_SET], n_cmd[CMD_READ], n_cmd[CMD_ALL_OFF], n_cmd[CMD_TICK], n_settings);
    $display("%0d results checked, %0d compare reloads, %0d mismatches",
             n_checked, n_reloads, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/hpwm_pkg.sv
sv/hpwm_if.sv
sv/hpwm_drive_calc.sv
sv/hbridge_pwm_motor_controller.sv
sv/hpwm_checker.sv
verif/tb_hbridge_pwm_motor_controller.sv
